// ----- design/max_pool_2d_stream_assert.svh -----
// assertion macros shared by the pooling block
`ifndef MAX_POOL_2D_STREAM_ASSERT_SVH
`define MAX_POOL_2D_STREAM_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MP2D_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mp2d assertion failed");

// consequent must hold in the cycle after the antecedent
`define MP2D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mp2d assertion failed");

`endif

// ----- design/mp2d_pkg.sv -----
`timescale 1ns / 1ps
package mp2d_pkg;

  // default sizes
  localparam int unsigned DefMaxCols    = 1024;
  localparam int unsigned DefMaxRows    = 1024;
  localparam int unsigned DefMaxPool    = 8;
  localparam int unsigned DefSampleBits = 16;

  // fixed field and register widths
  localparam int unsigned PosBits     = 20;
  localparam int unsigned DimRegBits  = 11;
  localparam int unsigned PoolRegBits = 4;
  localparam int unsigned ApbAddrBits = 4;
  localparam int unsigned ApbDataBits = 32;

  // register reset values
  localparam logic [DimRegBits-1:0]  ColsReset     = 11'd1024;
  localparam logic [DimRegBits-1:0]  RowsReset     = 11'd1024;
  localparam logic [PoolRegBits-1:0] PoolRowsReset = 4'd2;
  localparam logic [PoolRegBits-1:0] PoolColsReset = 4'd2;

  typedef enum logic [1:0] {
    REG_IMAGE_COLS = 2'd0,
    REG_IMAGE_ROWS = 2'd1,
    REG_POOL_ROWS  = 2'd2,
    REG_POOL_COLS  = 2'd3
  } reg_idx_e;

  // per-sample window status from the scan counters
  typedef struct packed {
    logic active;      // sample lies in a whole window
    logic first;       // first sample of its window
    logic last;        // last sample of its window
    logic frame_done;  // window is the last whole one of the frame
  } win_flags_t;

endpackage

// ----- design/max_pool_2d_stream.sv -----
`timescale 1ns / 1ps
// streaming 2-d max pooling over non-overlapping windows. samples of one frame
// enter in raster order, one per request, and one result leaves per whole
// window: its maximum, the flat image index of that maximum (row times
// image_cols plus column, kept to 20 bits) and tlast on the last whole window of
// the frame; ties go to the later sample, and trailing rows or columns that fill
// no whole window are dropped. the block sustains one sample per clock: each
// sample reads the running maximum of its window column from a single-port-read,
// single-port-write memory (one read and one write per cycle), compares and
// writes back from its stage register, with the last written entry forwarded
// when the next sample hits the same column, and a result is registered from
// that stage register; an output register lets the next sample enter
// while a result waits, and the input only stalls while a second completed
// window sits behind a result the receiver has not yet taken. no clearing pass
// is needed after reset since every window writes its entry on its first
// sample. register writes (image_cols, image_rows, pool_rows, pool_cols at byte
// addresses 0, 4, 8, 12) restart the frame at row 0, column 0 and must only be
// done while the block is idle
module max_pool_2d_stream #(
  parameter int unsigned MAX_COLS    = mp2d_pkg::DefMaxCols,
  parameter int unsigned MAX_ROWS    = mp2d_pkg::DefMaxRows,
  parameter int unsigned MAX_POOL    = mp2d_pkg::DefMaxPool,
  parameter int unsigned SAMPLE_BITS = mp2d_pkg::DefSampleBits
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // sample stream
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]           s_axis_tdata,  // sample
  // result stream
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // pooled_value, max_position, zero pad
  output logic [((SAMPLE_BITS+mp2d_pkg::PosBits+7)/8)*8-1:0] m_axis_tdata,
  output logic                                       m_axis_tlast,  // frame_done
  // register port
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [mp2d_pkg::ApbAddrBits-1:0]           paddr,
  input  logic [mp2d_pkg::ApbDataBits-1:0]           pwdata,
  output logic [mp2d_pkg::ApbDataBits-1:0]           prdata,
  output logic                                       pready
);
  import mp2d_pkg::*;

  localparam int unsigned CW      = $clog2(MAX_COLS + 1);
  localparam int unsigned RW      = $clog2(MAX_ROWS + 1);
  localparam int unsigned PW      = $clog2(MAX_POOL + 1);
  localparam int unsigned AW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned OutBits = ((SAMPLE_BITS + PosBits + 7) / 8) * 8;

  // clamped sizes from the register block
  logic [CW-1:0]                 cols;
  logic [RW-1:0]                 rows;
  logic [PW-1:0]                 pool_rows;
  logic [PW-1:0]                 pool_cols;
  logic                          restart;

  // scan position of the next sample
  logic [AW-1:0]                 win_addr;
  logic [PosBits-1:0]            win_pos;
  win_flags_t                    win_flags;

  logic                          in_accept;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic signed [SAMPLE_BITS-1:0] out_value;
  logic [PosBits-1:0]            out_pos;

  assign in_accept = s_axis_tvalid & s_axis_tready;
  assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];

  mp2d_cfg #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .MAX_POOL (MAX_POOL)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .restart_o   (restart),
    .cols_o      (cols),
    .rows_o      (rows),
    .pool_rows_o (pool_rows),
    .pool_cols_o (pool_cols)
  );

  // frame and window counters, advanced once per taken sample
  mp2d_scan #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .MAX_POOL (MAX_POOL)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .advance_i   (in_accept),
    .cols_i      (cols),
    .rows_i      (rows),
    .pool_rows_i (pool_rows),
    .pool_cols_i (pool_cols),
    .addr_o      (win_addr),
    .pos_o       (win_pos),
    .flags_o     (win_flags)
  );

  // read-modify-write of the per-column running maximum, plus output register
  mp2d_update #(
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (in_sample),
    .in_addr_i   (win_addr),
    .in_pos_i    (win_pos),
    .in_flags_i  (win_flags),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (out_value),
    .out_pos_o   (out_pos),
    .out_last_o  (m_axis_tlast)
  );

  // value in the low bits, position above it, zero padded to whole bytes
  assign m_axis_tdata = OutBits'({out_pos, out_value});

endmodule

// ----- design/mp2d_cfg.sv -----
`timescale 1ns / 1ps
module mp2d_cfg #(
  parameter int unsigned MAX_COLS = mp2d_pkg::DefMaxCols,
  parameter int unsigned MAX_ROWS = mp2d_pkg::DefMaxRows,
  parameter int unsigned MAX_POOL = mp2d_pkg::DefMaxPool
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mp2d_pkg::ApbAddrBits-1:0]      paddr,
  input  logic [mp2d_pkg::ApbDataBits-1:0]      pwdata,
  output logic [mp2d_pkg::ApbDataBits-1:0]      prdata,
  output logic                                  pready,
  output logic                                  restart_o,
  output logic [$clog2(MAX_COLS+1)-1:0]         cols_o,
  output logic [$clog2(MAX_ROWS+1)-1:0]         rows_o,
  output logic [$clog2(MAX_POOL+1)-1:0]         pool_rows_o,
  output logic [$clog2(MAX_POOL+1)-1:0]         pool_cols_o
);
  import mp2d_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_COLS + 1);
  localparam int unsigned RW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned PW  = $clog2(MAX_POOL + 1);
  localparam int unsigned CLW = (CW > DimRegBits) ? CW : DimRegBits;
  localparam int unsigned RLW = (RW > DimRegBits) ? RW : DimRegBits;
  localparam int unsigned PLW = (PW > PoolRegBits) ? PW : PoolRegBits;

  logic [DimRegBits-1:0]  image_cols_q, image_cols_d;
  logic [DimRegBits-1:0]  image_rows_q, image_rows_d;
  logic [PoolRegBits-1:0] pool_rows_q, pool_rows_d;
  logic [PoolRegBits-1:0] pool_cols_q, pool_cols_d;
  logic                   wr_en;
  reg_idx_e               idx;
  logic [CLW-1:0]         cols_raw;
  logic [RLW-1:0]         rows_raw;
  logic [PLW-1:0]         prows_raw;
  logic [PLW-1:0]         pcols_raw;

  assign pready    = 1'b1;
  assign idx       = reg_idx_e'(paddr[3:2]);
  assign wr_en     = psel & penable & pwrite & pready;
  assign restart_o = wr_en;

  always_comb begin
    image_cols_d = image_cols_q;
    image_rows_d = image_rows_q;
    pool_rows_d  = pool_rows_q;
    pool_cols_d  = pool_cols_q;
    if (wr_en) begin
      case (idx)
        REG_IMAGE_COLS: image_cols_d = pwdata[DimRegBits-1:0];
        REG_IMAGE_ROWS: image_rows_d = pwdata[DimRegBits-1:0];
        REG_POOL_ROWS:  pool_rows_d  = pwdata[PoolRegBits-1:0];
        REG_POOL_COLS:  pool_cols_d  = pwdata[PoolRegBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_cols_q <= ColsReset;
      image_rows_q <= RowsReset;
      pool_rows_q  <= PoolRowsReset;
      pool_cols_q  <= PoolColsReset;
    end else begin
      image_cols_q <= image_cols_d;
      image_rows_q <= image_rows_d;
      pool_rows_q  <= pool_rows_d;
      pool_cols_q  <= pool_cols_d;
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_COLS: prdata = ApbDataBits'(image_cols_q);
      REG_IMAGE_ROWS: prdata = ApbDataBits'(image_rows_q);
      REG_POOL_ROWS:  prdata = ApbDataBits'(pool_rows_q);
      REG_POOL_COLS:  prdata = ApbDataBits'(pool_cols_q);
      default:        prdata = '0;
    endcase
  end

  // clamp sizes into their legal ranges
  assign cols_raw  = CLW'(image_cols_q);
  assign rows_raw  = RLW'(image_rows_q);
  assign prows_raw = PLW'(pool_rows_q);
  assign pcols_raw = PLW'(pool_cols_q);

  always_comb begin
    if (cols_raw == '0) begin
      cols_o = CW'(1);
    end else if (cols_raw > CLW'(MAX_COLS)) begin
      cols_o = CW'(MAX_COLS);
    end else begin
      cols_o = CW'(cols_raw);
    end
    if (rows_raw == '0) begin
      rows_o = RW'(1);
    end else if (rows_raw > RLW'(MAX_ROWS)) begin
      rows_o = RW'(MAX_ROWS);
    end else begin
      rows_o = RW'(rows_raw);
    end
    if (prows_raw == '0) begin
      pool_rows_o = PW'(1);
    end else if (prows_raw > PLW'(MAX_POOL)) begin
      pool_rows_o = PW'(MAX_POOL);
    end else begin
      pool_rows_o = PW'(prows_raw);
    end
    if (pcols_raw == '0) begin
      pool_cols_o = PW'(1);
    end else if (pcols_raw > PLW'(MAX_POOL)) begin
      pool_cols_o = PW'(MAX_POOL);
    end else begin
      pool_cols_o = PW'(pcols_raw);
    end
  end

endmodule

// ----- design/mp2d_scan.sv -----
`timescale 1ns / 1ps
module mp2d_scan #(
  parameter int unsigned MAX_COLS = mp2d_pkg::DefMaxCols,
  parameter int unsigned MAX_ROWS = mp2d_pkg::DefMaxRows,
  parameter int unsigned MAX_POOL = mp2d_pkg::DefMaxPool
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        restart_i,
  input  logic                                        advance_i,
  input  logic [$clog2(MAX_COLS+1)-1:0]               cols_i,
  input  logic [$clog2(MAX_ROWS+1)-1:0]               rows_i,
  input  logic [$clog2(MAX_POOL+1)-1:0]               pool_rows_i,
  input  logic [$clog2(MAX_POOL+1)-1:0]               pool_cols_i,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] addr_o,
  output logic [mp2d_pkg::PosBits-1:0]                pos_o,
  output mp2d_pkg::win_flags_t                        flags_o
);
  import mp2d_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_COLS + 1);
  localparam int unsigned RW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned PW  = $clog2(MAX_POOL + 1);
  localparam int unsigned AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CXW = ((CW > PW) ? CW : PW) + 2;
  localparam int unsigned RXW = ((RW > PW) ? RW : PW) + 2;

  logic [CW-1:0]      col_q, col_d;
  logic [RW-1:0]      row_q, row_d;
  logic [PW-1:0]      cin_q, cin_d;
  logic [PW-1:0]      rin_q, rin_d;
  logic [AW-1:0]      wcol_q, wcol_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [CW-1:0]      col_start;
  logic [RW-1:0]      row_start;
  logic               col_fit, row_fit, col_tail, row_tail;

  // first column / row of the window holding this sample
  assign col_start = col_q - CW'(cin_q);
  assign row_start = row_q - RW'(rin_q);

  assign col_fit  = (CXW'(col_start) + CXW'(pool_cols_i)) <= CXW'(cols_i);
  assign row_fit  = (RXW'(row_start) + RXW'(pool_rows_i)) <= RXW'(rows_i);
  assign col_tail = (CXW'(col_start) + (CXW'(pool_cols_i) << 1)) > CXW'(cols_i);
  assign row_tail = (RXW'(row_start) + (RXW'(pool_rows_i) << 1)) > RXW'(rows_i);

  assign flags_o.active     = col_fit & row_fit;
  assign flags_o.first      = (cin_q == '0) && (rin_q == '0);
  assign flags_o.last       = (cin_q == (pool_cols_i - PW'(1))) &&
                              (rin_q == (pool_rows_i - PW'(1)));
  assign flags_o.frame_done = col_tail & row_tail;
  assign addr_o             = wcol_q;
  assign pos_o              = pos_q;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    cin_d  = cin_q;
    rin_d  = rin_q;
    wcol_d = wcol_q;
    pos_d  = pos_q;
    if (restart_i) begin
      col_d  = '0;
      row_d  = '0;
      cin_d  = '0;
      rin_d  = '0;
      wcol_d = '0;
      pos_d  = '0;
    end else if (advance_i) begin
      pos_d = pos_q + PosBits'(1);
      if ((cin_q + PW'(1)) >= pool_cols_i) begin
        cin_d  = '0;
        wcol_d = wcol_q + AW'(1);
      end else begin
        cin_d = cin_q + PW'(1);
      end
      if ((col_q + CW'(1)) >= cols_i) begin
        col_d  = '0;
        cin_d  = '0;
        wcol_d = '0;
        rin_d  = ((rin_q + PW'(1)) >= pool_rows_i) ? '0 : rin_q + PW'(1);
        if ((row_q + RW'(1)) >= rows_i) begin
          row_d = '0;
          rin_d = '0;
          pos_d = '0;
        end else begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      cin_q  <= '0;
      rin_q  <= '0;
      wcol_q <= '0;
      pos_q  <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      cin_q  <= cin_d;
      rin_q  <= rin_d;
      wcol_q <= wcol_d;
      pos_q  <= pos_d;
    end
  end

endmodule

// ----- design/mp2d_update.sv -----
`timescale 1ns / 1ps
`include "max_pool_2d_stream_assert.svh"
module mp2d_update #(
  parameter int unsigned MAX_COLS    = mp2d_pkg::DefMaxCols,
  parameter int unsigned SAMPLE_BITS = mp2d_pkg::DefSampleBits
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               in_valid_i,
  output logic                                               in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]                      in_sample_i,
  input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] in_addr_i,
  input  logic [mp2d_pkg::PosBits-1:0]                       in_pos_i,
  input  mp2d_pkg::win_flags_t                               in_flags_i,
  output logic                                               out_valid_o,
  input  logic                                               out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]                      out_value_o,
  output logic [mp2d_pkg::PosBits-1:0]                       out_pos_o,
  output logic                                               out_last_o
);
  import mp2d_pkg::*;

  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // per window column running maximum and its position
  logic signed [SAMPLE_BITS-1:0] max_mem [MAX_COLS];
  logic [PosBits-1:0]            pos_mem [MAX_COLS];

  logic signed [SAMPLE_BITS-1:0] rd_max_q;
  logic [PosBits-1:0]            rd_pos_q;

  logic                          s1_valid_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic [PosBits-1:0]            s1_pos_q;
  logic [AW-1:0]                 s1_addr_q;
  win_flags_t                    s1_flags_q;

  logic                          fwd_valid_q;
  logic [AW-1:0]                 fwd_addr_q;
  logic signed [SAMPLE_BITS-1:0] fwd_max_q;
  logic [PosBits-1:0]            fwd_pos_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_max_q;
  logic [PosBits-1:0]            out_pos_q;
  logic                          out_last_q;

  logic                          in_accept, in_ready;
  logic                          fwd_hit, take_new, produce, out_free, s1_move, wr_en;
  logic signed [SAMPLE_BITS-1:0] old_max, new_max;
  logic [PosBits-1:0]            old_pos, new_pos;

  assign in_accept = in_valid_i & in_ready;

  // read port, issued as the request is taken
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_max_q <= max_mem[in_addr_i];
      rd_pos_q <= pos_mem[in_addr_i];
    end
  end

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      max_mem[s1_addr_q] <= new_max;
      pos_mem[s1_addr_q] <= new_pos;
    end
  end

  // the previous request may write the same entry on the edge this one reads it
  assign fwd_hit  = fwd_valid_q && (fwd_addr_q == s1_addr_q);
  assign old_max  = fwd_hit ? fwd_max_q : rd_max_q;
  assign old_pos  = fwd_hit ? fwd_pos_q : rd_pos_q;
  assign take_new = s1_flags_q.first || (s1_sample_q >= old_max);
  assign new_max  = take_new ? s1_sample_q : old_max;
  assign new_pos  = take_new ? s1_pos_q : old_pos;

  assign produce  = s1_flags_q.active & s1_flags_q.last;
  assign out_free = !out_valid_q || out_ready_i;
  assign s1_move  = s1_valid_q && (!produce || out_free);
  assign in_ready = !s1_valid_q || s1_move;
  assign wr_en    = s1_move && s1_flags_q.active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (wr_en) begin
        fwd_valid_q <= 1'b1;
      end
      if (s1_move && produce) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= in_sample_i;
      s1_pos_q    <= in_pos_i;
      s1_addr_q   <= in_addr_i;
      s1_flags_q  <= in_flags_i;
    end
    if (wr_en) begin
      fwd_addr_q <= s1_addr_q;
      fwd_max_q  <= new_max;
      fwd_pos_q  <= new_pos;
    end
    if (s1_move && produce) begin
      out_max_q  <= new_max;
      out_pos_q  <= new_pos;
      out_last_q <= s1_flags_q.frame_done;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_value_o = out_max_q;
  assign out_pos_o   = out_pos_q;
  assign out_last_o  = out_last_q;

  `MP2D_ASSERT_SAME(a_blocked_stage_stalls_input, (s1_valid_q && produce && !out_free), !in_ready)
  `MP2D_ASSERT_SAME(a_write_from_active_stage, wr_en, (s1_valid_q && s1_flags_q.active))
  `MP2D_ASSERT_NEXT(a_forward_tracks_write, wr_en, (fwd_valid_q && (fwd_addr_q == $past(s1_addr_q))))
  `MP2D_ASSERT_NEXT(a_result_not_below_sample, (s1_move && produce), (out_valid_q && (out_max_q >= $past(s1_sample_q))))

endmodule
